/* rtl/core/bchd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchd_pkg
// Types and constants shared by the button click and hold detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_ACTIVE     = 3'd1,
        MODE_CLICKED    = 3'd2,
        MODE_DOUBLE     = 3'd3,
        MODE_RELEASED   = 3'd4,
        MODE_FIRST_HELD = 3'd5,
        MODE_HELD       = 3'd6
    } mode_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_MS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_ENABLE   = 3'd4;

    localparam logic [15:0] DEBOUNCE_MS_RESET     = 16'd10;
    localparam logic [15:0] HOLD_MS_RESET         = 16'd2000;
    localparam logic [15:0] DOUBLE_CLICK_MS_RESET = 16'd300;

    localparam logic [3:0] PRESS_LIMIT = 4'd10;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] now_ms;
        logic        claim_valid;
        logic [3:0]  claim_count;
    } poll_t;

    typedef struct packed {
        logic       clicked;
        logic       dbl_click;
        logic       hold_begin;
        logic       released;
        logic [3:0] press_total;
        logic       claim_hit;
    } report_t;

endpackage

/* rtl/core/button_click_hold_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Debounced push-button poller reporting click, double click, hold, release.
// ----------------------------------------------------------------------------
// Usage:
//   Each poll word carries the raw pin level, a free-running millisecond
//   time and an optional press-count claim; one report word is returned per
//   poll, in order. Both channels use valid/ready.
//   Each poll is held in the input register, then passes once through the
//   mode logic into the report register.
//   Throughput: one poll per cycle, limited only by report_ready.
//   When the receiver stalls, the report register holds and the input
//   register fills; poll_ready drops only when both are occupied.
//   Reset clears the mode to idle, the settled flag to set, both time stamps
//   and the press counter to zero, and the registers to their defaults:
//   debounce 10 ms, hold 2000 ms, double click 300 ms, active high, double
//   click reporting on. Write registers through cfg_we/cfg_index/cfg_data
//   only while no poll is in flight.
// ----------------------------------------------------------------------------
module button_click_hold_detector
    import bchd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   poll_valid,
    output logic                   poll_ready,
    input  poll_t                  poll,
    output logic                   report_valid,
    input  logic                   report_ready,
    output report_t                report,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [15:0] debounce_ms_reg;
    logic [15:0] hold_ms_reg;
    logic [15:0] double_click_ms_reg;
    logic        active_level_reg;
    logic        double_enable_reg;

    logic        poll_valid_reg;
    poll_t       poll_reg;
    logic        report_valid_reg;
    report_t     report_reg;
    report_t     report_next;

    mode_t       mode_reg,        mode_next;
    logic        settled_reg,     settled_next;
    logic [31:0] click_time_reg,  click_time_next;
    logic [31:0] release_time_reg, release_time_next;
    logic [3:0]  press_count_reg, press_count_next;

    logic        advance;
    logic        pressed;
    logic [31:0] since_click;
    logic [31:0] since_release;
    logic [3:0]  press_base;
    logic        hit;

    assign advance    = !report_valid_reg || report_ready;
    assign poll_ready = !poll_valid_reg || advance;

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg     <= DEBOUNCE_MS_RESET;
            hold_ms_reg         <= HOLD_MS_RESET;
            double_click_ms_reg <= DOUBLE_CLICK_MS_RESET;
            active_level_reg    <= 1'b1;
            double_enable_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE_MS:     debounce_ms_reg     <= cfg_data;
                REG_HOLD_MS:         hold_ms_reg         <= cfg_data;
                REG_DOUBLE_CLICK_MS: double_click_ms_reg <= cfg_data;
                REG_ACTIVE_LEVEL:    active_level_reg    <= cfg_data[0];
                REG_DOUBLE_ENABLE:   double_enable_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Next state
    assign pressed       = (poll_reg.pin_level == active_level_reg);
    assign since_click   = poll_reg.now_ms - click_time_reg;
    assign since_release = poll_reg.now_ms - release_time_reg;
    assign press_base    = (press_count_reg > PRESS_LIMIT) ? 4'd0 : press_count_reg;

    always_comb
    begin
        mode_next         = mode_reg;
        settled_next      = settled_reg;
        click_time_next   = click_time_reg;
        release_time_next = release_time_reg;
        press_count_next  = press_base;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (settled_reg)
                begin
                    if (pressed)
                    begin
                        mode_next = (since_click < {16'd0, double_click_ms_reg})
                                    ? MODE_DOUBLE : MODE_CLICKED;
                        press_count_next = press_base + 4'd1;
                        settled_next     = 1'b0;
                        click_time_next  = poll_reg.now_ms;
                    end
                end
                else if (since_release > {16'd0, debounce_ms_reg})
                begin
                    settled_next = 1'b1;
                end
            end
            MODE_ACTIVE:
            begin
                if (settled_reg)
                begin
                    if (!pressed)
                        mode_next = MODE_RELEASED;
                    else if (since_click > {16'd0, hold_ms_reg})
                        mode_next = MODE_FIRST_HELD;
                end
                else if (since_click > {16'd0, debounce_ms_reg})
                begin
                    settled_next = 1'b1;
                end
            end
            MODE_CLICKED,
            MODE_DOUBLE:
                mode_next = MODE_ACTIVE;
            MODE_RELEASED:
            begin
                mode_next         = MODE_IDLE;
                settled_next      = 1'b0;
                release_time_next = poll_reg.now_ms;
            end
            MODE_FIRST_HELD:
                mode_next = MODE_HELD;
            MODE_HELD:
            begin
                if (!pressed)
                    mode_next = MODE_RELEASED;
            end
            default:
                mode_next = MODE_IDLE;
        endcase
        hit = poll_reg.claim_valid && (press_count_next == poll_reg.claim_count);
    end

    // Report
    always_comb
    begin
        report_next.clicked     = (mode_next == MODE_CLICKED);
        report_next.dbl_click   = (mode_next == MODE_DOUBLE) && double_enable_reg;
        report_next.hold_begin  = (mode_next == MODE_FIRST_HELD);
        report_next.released    = (mode_next == MODE_RELEASED);
        report_next.press_total = press_count_next;
        report_next.claim_hit   = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg   <= 1'b0;
            report_valid_reg <= 1'b0;
            mode_reg         <= MODE_IDLE;
            settled_reg      <= 1'b1;
            click_time_reg   <= 32'd0;
            release_time_reg <= 32'd0;
            press_count_reg  <= 4'd0;
        end
        else
        begin
            if (poll_ready)
                poll_valid_reg <= poll_valid;
            if (advance)
                report_valid_reg <= poll_valid_reg;
            if (poll_valid_reg && advance)
            begin
                mode_reg         <= mode_next;
                settled_reg      <= settled_next;
                click_time_reg   <= click_time_next;
                release_time_reg <= release_time_next;
                press_count_reg  <= hit ? 4'd0 : press_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
            poll_reg <= poll;
        if (poll_valid_reg && advance)
            report_reg <= report_next;
    end

endmodule

/* dv/button_click_hold_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector_tb
// Self-checking bench for the push-button click, double click and hold poller.
// Polls go in through valid/ready with random gaps, reports come back under
// random stalls. An in-bench model of the mode machine, the debounce flag,
// the time stamps and the press counter predicts every report, and a small
// scoreboard compares each one in order. The run walks several register
// settings, the extremes among them, with time wrap and press-count claims.
// ----------------------------------------------------------------------------
module button_click_hold_detector_tb;
    import bchd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 150;

    class click_scoreboard;
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
        logic [15:0] double_ms;
        logic        active_level;
        logic        double_enable;
        mode_t       mode;
        logic        settled;
        logic [31:0] last_click;
        logic [31:0] last_release;
        logic [3:0]  presses;
        report_t     pending_reports[$];
        int unsigned polls, reports, errors;
        int unsigned clicks, doubles, holds, releases, hits, overflows;

        function new();
            debounce_ms   = DEBOUNCE_MS_RESET;
            hold_ms       = HOLD_MS_RESET;
            double_ms     = DOUBLE_CLICK_MS_RESET;
            active_level  = 1'b1;
            double_enable = 1'b1;
            mode          = MODE_IDLE;
            settled       = 1'b1;
            last_click    = '0;
            last_release  = '0;
            presses       = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEBOUNCE_MS:     debounce_ms = data;
                REG_HOLD_MS:         hold_ms = data;
                REG_DOUBLE_CLICK_MS: double_ms = data;
                REG_ACTIVE_LEVEL:    active_level = data[0];
                REG_DOUBLE_ENABLE:   double_enable = data[0];
                default: ;
            endcase
        endfunction

        function void note_poll(poll_t p);
            logic        pressed;
            logic [31:0] since_click;
            logic [31:0] since_release;
            report_t     r;
            pressed       = (p.pin_level == active_level);
            since_click   = p.now_ms - last_click;
            since_release = p.now_ms - last_release;
            polls++;
            if (presses > PRESS_LIMIT)
            begin
                presses = '0;
                overflows++;
            end
            case (mode)
                MODE_IDLE:
                begin
                    if (settled)
                    begin
                        if (pressed)
                        begin
                            mode = (since_click < double_ms) ? MODE_DOUBLE : MODE_CLICKED;
                            presses = presses + 4'd1;
                            settled = 1'b0;
                            last_click = p.now_ms;
                        end
                    end
                    else if (since_release > debounce_ms)
                        settled = 1'b1;
                end
                MODE_ACTIVE:
                begin
                    if (settled)
                    begin
                        if (!pressed)
                            mode = MODE_RELEASED;
                        else if (since_click > hold_ms)
                            mode = MODE_FIRST_HELD;
                    end
                    else if (since_click > debounce_ms)
                        settled = 1'b1;
                end
                MODE_CLICKED, MODE_DOUBLE: mode = MODE_ACTIVE;
                MODE_RELEASED:
                begin
                    mode = MODE_IDLE;
                    settled = 1'b0;
                    last_release = p.now_ms;
                end
                MODE_FIRST_HELD: mode = MODE_HELD;
                MODE_HELD:
                begin
                    if (!pressed)
                        mode = MODE_RELEASED;
                end
                default: mode = MODE_IDLE;
            endcase
            r.clicked     = (mode == MODE_CLICKED);
            r.dbl_click   = (mode == MODE_DOUBLE) && double_enable;
            r.hold_begin  = (mode == MODE_FIRST_HELD);
            r.released    = (mode == MODE_RELEASED);
            r.press_total = presses;
            r.claim_hit   = p.claim_valid && (presses == p.claim_count);
            if (r.claim_hit)
            begin
                presses = '0;
                hits++;
            end
            clicks   += (mode == MODE_CLICKED);
            doubles  += (mode == MODE_DOUBLE);
            holds    += (mode == MODE_FIRST_HELD);
            releases += (mode == MODE_RELEASED);
            pending_reports.push_back(r);
        endfunction

        function void check_report(report_t got);
            report_t want;
            reports++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report word %0d: %p", reports, got);
                return;
            end
            want = pending_reports.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("report word %0d mismatch: expected %p, got %p",
                             reports, want, got);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    poll_valid;
    logic    poll_ready;
    poll_t   poll;
    logic    report_valid;
    logic    report_ready;
    report_t report;
    logic    cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    click_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;

    button_click_hold_detector dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d reports outstanding", sb.pending_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // receive side: check accepted words, stall at random
    initial
    begin
        report_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (report_valid && report_ready)
                sb.check_report(report);
            report_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_poll(input logic pin, input logic [31:0] t,
                             input logic cv, input logic [3:0] cc);
        poll_t p;
        p.pin_level   = pin;
        p.now_ms      = t;
        p.claim_valid = cv;
        p.claim_count = cc;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            poll_valid <= 1'b0;
            @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll       <= p;
        @(posedge clk);
        while (!poll_ready)
            @(posedge clk);
        sb.note_poll(p);
    endtask

    // drop valid and hold until every report is back or the wait limit runs out
    task automatic drain();
        int unsigned waited;
        waited = 0;
        poll_valid <= 1'b0;
        while (sb.pending_reports.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] db, input logic [15:0] hold,
                                 input logic [15:0] dc, input logic lvl, input logic en);
        logic [CFG_INDEX_W-1:0] widx;
        logic [CFG_DATA_W-1:0]  wdata;
        cfg_we <= 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0: begin widx = REG_DEBOUNCE_MS;     wdata = db;                     end
                1: begin widx = REG_HOLD_MS;         wdata = hold;                   end
                2: begin widx = REG_DOUBLE_CLICK_MS; wdata = dc;                     end
                3: begin widx = REG_ACTIVE_LEVEL;    wdata = {15'($urandom), lvl};   end
                4: begin widx = REG_DOUBLE_ENABLE;   wdata = {15'($urandom), en};    end
                default: begin widx = REG_SPARE;     wdata = 16'($urandom);          end
            endcase
            cfg_index <= widx;
            cfg_data  <= wdata;
            @(posedge clk);
            sb.write_reg(widx, wdata);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned count, input int unsigned step_max,
                             input int unsigned claim_pct);
        logic [31:0] t;
        logic        want_press;
        logic        pin;
        logic [3:0]  claim;
        int unsigned run_len;
        int unsigned sent;
        t = $urandom;
        want_press = 1'b0;
        sent = 0;
        while (sent < count)
        begin
            if (want_press && $urandom_range(0, 5) == 0)
                run_len = $urandom_range(30, 120);
            else
                run_len = $urandom_range(1, 8);
            for (int k = 0; k < run_len && sent < count; k++)
            begin
                t = t + $urandom_range(0, step_max);
                if ($urandom_range(0, 99) < 3)
                    t = $urandom;
                pin = want_press ? sb.active_level : ~sb.active_level;
                if ($urandom_range(0, 99) < 10)
                    pin = 1'($urandom);
                if ($urandom_range(0, 2) == 0)
                    claim = sb.presses + 4'($urandom_range(0, 1));
                else
                    claim = 4'($urandom);
                send_poll(pin, t, $urandom_range(0, 99) < claim_pct, claim);
                sent++;
            end
            want_press = ~want_press;
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 21;
        recv_idle_pct = 48;
        rst_n      <= 1'b0;
        poll_valid <= 1'b0;
        poll       <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk with reset settings
        send_poll(1'b0, 32'd0, 1'b1, 4'd0);
        send_poll(1'b1, 32'd5, 1'b0, 4'd0);
        send_poll(1'b1, 32'd6, 1'b1, 4'd15);
        send_poll(1'b1, 32'd20, 1'b0, 4'd0);
        send_poll(1'b1, 32'd2100, 1'b0, 4'd0);
        send_poll(1'b1, 32'd2101, 1'b0, 4'd0);
        send_poll(1'b0, 32'd2102, 1'b0, 4'd0);
        send_poll(1'b0, 32'd2103, 1'b0, 4'd0);
        send_poll(1'b0, 32'd2200, 1'b0, 4'd0);
        send_poll(1'b1, 32'd3000, 1'b0, 4'd0);
        send_poll(1'b1, 32'd3001, 1'b0, 4'd0);
        send_poll(1'b0, 32'd3020, 1'b0, 4'd0);
        send_poll(1'b0, 32'd3021, 1'b0, 4'd0);
        send_poll(1'b0, 32'd3022, 1'b0, 4'd0);
        send_poll(1'b0, 32'd3040, 1'b0, 4'd0);
        send_poll(1'b1, 32'd3100, 1'b1, 4'd3);
        send_poll(1'b1, 32'hFFFF_FF00, 1'b0, 4'd0);
        send_poll(1'b1, 32'hFFFF_FFFF, 1'b1, 4'd15);
        send_poll(1'b0, 32'h0000_0005, 1'b0, 4'd0);
        send_poll(1'b0, 32'h0000_0006, 1'b0, 4'd0);
        send_poll(1'b0, 32'h0000_0010, 1'b0, 4'd0);
        send_poll(1'b0, 32'h0000_0011, 1'b0, 4'd0);
        send_poll(1'b1, 32'h0000_0012, 1'b1, 4'd1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if (ph < 2)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 48;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0:
                begin
                    apply_setting(DEBOUNCE_MS_RESET, HOLD_MS_RESET, DOUBLE_CLICK_MS_RESET,
                                  1'b1, 1'b1);
                    run_phase(PHASE_LEN, 60, 6);
                end
                1:
                begin
                    apply_setting(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
                    run_phase(PHASE_LEN, 3, 2);
                end
                2:
                begin
                    apply_setting(16'($urandom_range(1, 20)), 16'($urandom_range(20, 200)),
                                  16'($urandom_range(10, 150)), 1'($urandom), 1'($urandom));
                    run_phase(PHASE_LEN, 15, 8);
                end
                3:
                begin
                    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
                    run_phase(PHASE_LEN, 9000, 6);
                end
                4:
                begin
                    apply_setting(16'($urandom_range(1, 20)), 16'($urandom_range(20, 200)),
                                  16'($urandom_range(10, 150)), 1'b0, 1'b1);
                    run_phase(PHASE_LEN, 15, 2);
                end
                default:
                begin
                    apply_setting(16'($urandom_range(1, 20)), 16'($urandom_range(20, 200)),
                                  16'($urandom_range(10, 150)), 1'b1, 1'b0);
                    run_phase(PHASE_LEN, 15, 8);
                end
            endcase
        end

        drain();
        repeat (10) @(posedge clk);
        sb.errors += sb.pending_reports.size();
        $display("%0d polls over %0d register settings, %0d reports checked, %0d errors",
                 sb.polls, PHASES + 1, sb.reports, sb.errors);
        $display("clicks %0d, double clicks %0d, holds %0d, releases %0d, claim hits %0d, counter wraps past ten %0d",
                 sb.clicks, sb.doubles, sb.holds, sb.releases, sb.hits, sb.overflows);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
